### sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MBRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbrr: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define MBRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbrr: next-cycle check failed");

// Next-cycle implication, active during reset as well.
`define MBRR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mbrr: reset check failed");

`endif

### sv/mbrr_pkg.sv
// Types, constants and the CRC-16/Modbus byte update for the Modbus RTU read unit.
// No dependencies; imported by mbrr_tx_seq and the top level.
package mbrr_pkg;

    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HDR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CRC = 2'd3;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] REG_COUNT         = 16'h0001;
    localparam logic [7:0]  RESP_BYTE_COUNT   = 8'h02;

    typedef struct packed {
        logic        valid;
        logic [7:0]  slave_address;
        logic [15:0] register_address;
    } tx_load_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/modbus_rtu_single_register_read_unit.sv
// Top level of the Modbus RTU single holding-register read unit (master side).
// Depends on mbrr_pkg and mbrr_tx_seq.
//
// Usage:
//   Input beats on s_*: s_tuser is the operation (start, received byte,
//   timeout); s_tdata carries slave address, register address and the
//   received byte. A start produces eight transmit beats on m_* (m_tuser
//   low, m_tlast on the last CRC byte) and arms reception. Seven received
//   bytes or a timeout produce one completion beat (m_tuser high) with
//   status and register value. Other beats produce nothing.
// Path: an input beat is held in the input register; a completion then
//   passes to the output register, a request byte first through the
//   sequencer and then the output register.
// Throughput: one received byte or timeout per cycle, unless the beat needs a
//   stalled output. After a start, the next beat waits in the input register
//   until the eight request bytes have left the sequencer.
// Reset: aresetn (synchronous, active low) drops any pending beat, stops the
//   sequencer and returns to idle with no reply expected.
// Stall: while m_tready is low the output beat holds; beats that produce no
//   result still pass, while a beat that needs the output, or any beat while
//   request bytes are pending, holds in the input register and s_tready drops.
module modbus_rtu_single_register_read_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] slave_address, [23:8] register_address, [31:24] rx_byte
    input  logic [mbrr_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [1:0] operation
    input  logic [mbrr_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] tx_byte, [9:8] status, [25:10] read_value, [31:26] zero
    output logic [mbrr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // [0] kind
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import mbrr_pkg::*;

    localparam logic [2:0] RX_POS_ADDR   = 3'd0;
    localparam logic [2:0] RX_POS_FUNC   = 3'd1;
    localparam logic [2:0] RX_POS_COUNT  = 3'd2;
    localparam logic [2:0] RX_POS_DATA_H = 3'd3;
    localparam logic [2:0] RX_POS_DATA_L = 3'd4;
    localparam logic [2:0] RX_POS_CRC_LO = 3'd5;
    localparam logic [2:0] RX_POS_CRC_HI = 3'd6;

    logic            in_valid_reg;
    logic [OP_W-1:0] in_op_reg;
    logic [7:0]      in_slave_reg;
    logic [15:0]     in_regaddr_reg;
    logic [7:0]      in_rx_reg;

    logic        awaiting_reg, awaiting_next;
    logic [2:0]  rx_cnt_reg, rx_cnt_next;
    logic [7:0]  exp_addr_reg, exp_addr_next;
    logic        hdr_good_reg, hdr_good_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [15:0] data_word_reg, data_word_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                   m_kind_reg, m_kind_next;
    logic                   m_last_reg, m_last_next;

    logic          out_free;
    logic          in_take;
    logic          is_start, is_byte, is_timeout;
    logic          done_byte, done_to, needs_out;
    logic          consume;
    logic [15:0]   rx_got;
    logic [STATUS_W-1:0] done_status;
    logic [15:0]   done_value;
    tx_load_t      tx_load;
    tx_beat_t      tx_beat;
    logic          tx_busy;

    assign out_free   = !m_valid_reg || m_tready;
    assign is_start   = (in_op_reg == OP_START);
    assign is_byte    = (in_op_reg == OP_RX_BYTE);
    assign is_timeout = (in_op_reg == OP_TIMEOUT);
    assign done_byte  = is_byte && awaiting_reg && (rx_cnt_reg == RX_POS_CRC_HI);
    assign done_to    = is_timeout && awaiting_reg;
    assign needs_out  = done_byte || done_to;
    assign consume    = in_valid_reg && !tx_busy && (!needs_out || out_free);
    assign s_tready   = !in_valid_reg || consume;
    assign in_take    = s_tvalid && s_tready;

    assign tx_load.valid            = consume && is_start;
    assign tx_load.slave_address    = in_slave_reg;
    assign tx_load.register_address = in_regaddr_reg;

    mbrr_tx_seq u_tx_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (tx_load),
        .advance (out_free),
        .beat    (tx_beat),
        .busy    (tx_busy)
    );

    // completion fields
    assign rx_got = {in_rx_reg, crc_lo_reg};
    always_comb begin
        done_value = 16'h0000;
        priority if (done_to) begin
            done_status = ST_SHORT;
        end else if (!hdr_good_reg) begin
            done_status = ST_BAD_HDR;
        end else if (rx_got != rx_crc_reg) begin
            done_status = ST_BAD_CRC;
        end else begin
            done_status = ST_OK;
            done_value  = data_word_reg;
        end
    end

    // receive state
    always_comb begin
        awaiting_next  = awaiting_reg;
        rx_cnt_next    = rx_cnt_reg;
        exp_addr_next  = exp_addr_reg;
        hdr_good_next  = hdr_good_reg;
        rx_crc_next    = rx_crc_reg;
        data_word_next = data_word_reg;
        crc_lo_next    = crc_lo_reg;
        if (consume) begin
            if (is_start) begin
                awaiting_next  = 1'b1;
                rx_cnt_next    = RX_POS_ADDR;
                exp_addr_next  = in_slave_reg;
                hdr_good_next  = 1'b1;
                rx_crc_next    = CRC_INIT;
                data_word_next = 16'h0000;
                crc_lo_next    = 8'h00;
            end else if (needs_out) begin
                awaiting_next = 1'b0;
                rx_cnt_next   = RX_POS_ADDR;
            end else if (is_byte && awaiting_reg) begin
                unique case (rx_cnt_reg)
                    RX_POS_ADDR: begin
                        if (in_rx_reg != exp_addr_reg) hdr_good_next = 1'b0;
                    end
                    RX_POS_FUNC: begin
                        if (in_rx_reg != FUNC_READ_HOLDING) hdr_good_next = 1'b0;
                    end
                    RX_POS_COUNT: begin
                        if (in_rx_reg != RESP_BYTE_COUNT) hdr_good_next = 1'b0;
                    end
                    RX_POS_DATA_H: data_word_next = {in_rx_reg, data_word_reg[7:0]};
                    RX_POS_DATA_L: data_word_next = {data_word_reg[15:8], in_rx_reg};
                    RX_POS_CRC_LO: crc_lo_next = in_rx_reg;
                    default: ;
                endcase
                if (rx_cnt_reg < RX_POS_CRC_LO) begin
                    rx_crc_next = crc_update(rx_crc_reg, in_rx_reg);
                end
                rx_cnt_next = rx_cnt_reg + 3'd1;
            end
        end
    end

    // output register: request bytes and completions never compete
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;
        if (out_free) begin
            m_valid_next = tx_beat.valid || (consume && needs_out);
            if (tx_beat.valid) begin
                m_kind_next = KIND_TX;
                m_last_next = tx_beat.last;
                m_data_next = {{(OUT_TDATA_W - 8){1'b0}}, tx_beat.data};
            end else begin
                m_kind_next = KIND_DONE;
                m_last_next = 1'b0;
                m_data_next = {{(OUT_TDATA_W - 26){1'b0}}, done_value, done_status, 8'h00};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            awaiting_reg  <= 1'b0;
            rx_cnt_reg    <= RX_POS_ADDR;
            exp_addr_reg  <= 8'h00;
            hdr_good_reg  <= 1'b1;
            rx_crc_reg    <= CRC_INIT;
            data_word_reg <= 16'h0000;
            crc_lo_reg    <= 8'h00;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            awaiting_reg  <= awaiting_next;
            rx_cnt_reg    <= rx_cnt_next;
            exp_addr_reg  <= exp_addr_next;
            hdr_good_reg  <= hdr_good_next;
            rx_crc_reg    <= rx_crc_next;
            data_word_reg <= data_word_next;
            crc_lo_reg    <= crc_lo_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg      <= s_tuser;
            in_slave_reg   <= s_tdata[7:0];
            in_regaddr_reg <= s_tdata[23:8];
            in_rx_reg      <= s_tdata[31:24];
        end
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

### sv/mbrr_tx_seq.sv
// Request sequencer: emits the eight request bytes, folding the CRC one byte per beat.
// Depends on mbrr_pkg.
module mbrr_tx_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbrr_pkg::tx_load_t load,
    input  logic               advance,
    output mbrr_pkg::tx_beat_t beat,
    output logic               busy
);
    import mbrr_pkg::*;

    localparam logic [2:0] POS_ADDR   = 3'd0;
    localparam logic [2:0] POS_FUNC   = 3'd1;
    localparam logic [2:0] POS_REG_HI = 3'd2;
    localparam logic [2:0] POS_REG_LO = 3'd3;
    localparam logic [2:0] POS_CNT_HI = 3'd4;
    localparam logic [2:0] POS_CNT_LO = 3'd5;
    localparam logic [2:0] POS_CRC_LO = 3'd6;
    localparam logic [2:0] POS_CRC_HI = 3'd7;

    logic        active_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic [7:0]  slave_reg;
    logic [15:0] regaddr_reg;
    logic [7:0]  byte_sel;
    logic        step;

    always_comb begin
        unique case (idx_reg)
            POS_ADDR:   byte_sel = slave_reg;
            POS_FUNC:   byte_sel = FUNC_READ_HOLDING;
            POS_REG_HI: byte_sel = regaddr_reg[15:8];
            POS_REG_LO: byte_sel = regaddr_reg[7:0];
            POS_CNT_HI: byte_sel = REG_COUNT[15:8];
            POS_CNT_LO: byte_sel = REG_COUNT[7:0];
            POS_CRC_LO: byte_sel = crc_reg[7:0];
            POS_CRC_HI: byte_sel = crc_reg[15:8];
            default:    byte_sel = 8'h00;
        endcase
    end

    assign step       = active_reg && advance;
    assign busy       = active_reg;
    assign beat.valid = active_reg;
    assign beat.data  = byte_sel;
    assign beat.last  = (idx_reg == POS_CRC_HI);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= POS_ADDR;
        end else if (load.valid) begin
            active_reg <= 1'b1;
            idx_reg    <= POS_ADDR;
        end else if (step) begin
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg == POS_CRC_HI) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            crc_reg     <= CRC_INIT;
            slave_reg   <= load.slave_address;
            regaddr_reg <= load.register_address;
        end else if (step && (idx_reg < POS_CRC_LO)) begin
            crc_reg <= crc_update(crc_reg, byte_sel);
        end
    end

endmodule

### sv/mbrr_checker.sv
// Port-level checks for the Modbus RTU read unit, bound to the top level.
// Depends on assert_macros.svh and mbrr_pkg.
`include "assert_macros.svh"

module mbrr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mbrr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);
    import mbrr_pkg::*;

    `MBRR_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_tvalid)
    `MBRR_ASSERT_IMPLY(a_done_fields, aclk, aresetn, m_tvalid && (m_tuser == KIND_DONE),
        !m_tlast && (m_tdata[7:0] == 8'h00) && (m_tdata[31:26] == 6'd0))
    `MBRR_ASSERT_IMPLY(a_tx_fields, aclk, aresetn, m_tvalid && (m_tuser == KIND_TX),
        m_tdata[31:8] == 24'h000000)
    `MBRR_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `MBRR_ASSERT_IMPLY(a_value_only_ok, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_DONE) && (m_tdata[9:8] != ST_OK),
        m_tdata[25:10] == 16'h0000)

endmodule

bind modbus_rtu_single_register_read_unit mbrr_checker u_mbrr_checker (.*);

### tb/modbus_rtu_single_register_read_unit_tb.sv
// Testbench for modbus_rtu_single_register_read_unit: request framing, reply checks, timeouts.
// Drives start, byte and timeout beats, predicts each request and completion beat, and
// compares them in order. Depends on mbrr_pkg and the unit's RTL.
module modbus_rtu_single_register_read_unit_tb;
    import mbrr_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic                kind;
        logic [7:0]          tx;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [15:0]         value;
    } out_beat_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    modbus_rtu_single_register_read_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    out_beat_t outgoing_q[$];
    out_beat_t head_beat;
    int mismatches = 0;
    int stuck_cycles = 0;
    int sent_items = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    // reply tracking of the master
    logic        rx_armed = 1'b0;
    logic [2:0]  rx_count = '0;
    logic [7:0]  rx_addr = '0;
    logic        rx_header_ok = 1'b1;
    logic [15:0] rx_crc = CRC_INIT;
    logic [15:0] rx_value = '0;
    logic [7:0]  rx_crc_low = '0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic out_beat_t pack_beat(input logic kind, input logic [7:0] tx,
                                            input logic last, input logic [STATUS_W-1:0] st,
                                            input logic [15:0] value);
        out_beat_t b;
        b.kind = kind;
        b.tx = tx;
        b.last = last;
        b.status = st;
        b.value = value;
        return b;
    endfunction

    function automatic void modbus_master_step(input logic [OP_W-1:0] op, input logic [7:0] sa,
                                               input logic [15:0] ra, input logic [7:0] rb);
        logic [7:0]  req [8];
        logic [15:0] c;
        logic [15:0] got;
        case (op)
            OP_START: begin
                req[0] = sa;
                req[1] = FUNC_READ_HOLDING;
                req[2] = ra[15:8];
                req[3] = ra[7:0];
                req[4] = REG_COUNT[15:8];
                req[5] = REG_COUNT[7:0];
                c = CRC_INIT;
                for (int i = 0; i < 6; i++) begin
                    c = crc16_byte(c, req[i]);
                end
                req[6] = c[7:0];
                req[7] = c[15:8];
                for (int i = 0; i < 8; i++) begin
                    outgoing_q.push_back(pack_beat(KIND_TX, req[i], i == 7, ST_OK, 16'h0000));
                end
                rx_armed = 1'b1;
                rx_count = '0;
                rx_addr = sa;
                rx_header_ok = 1'b1;
                rx_crc = CRC_INIT;
                rx_value = '0;
                rx_crc_low = '0;
            end
            OP_RX_BYTE: begin
                if (rx_armed) begin
                    if (rx_count == 3'd6) begin
                        got = {rb, rx_crc_low};
                        if (!rx_header_ok) begin
                            outgoing_q.push_back(pack_beat(KIND_DONE, 8'h00, 1'b0, ST_BAD_HDR,
                                                           16'h0000));
                        end else if (got != rx_crc) begin
                            outgoing_q.push_back(pack_beat(KIND_DONE, 8'h00, 1'b0, ST_BAD_CRC,
                                                           16'h0000));
                        end else begin
                            outgoing_q.push_back(pack_beat(KIND_DONE, 8'h00, 1'b0, ST_OK,
                                                           rx_value));
                        end
                        rx_armed = 1'b0;
                        rx_count = '0;
                    end else begin
                        case (rx_count)
                            3'd0: if (rb != rx_addr) rx_header_ok = 1'b0;
                            3'd1: if (rb != FUNC_READ_HOLDING) rx_header_ok = 1'b0;
                            3'd2: if (rb != RESP_BYTE_COUNT) rx_header_ok = 1'b0;
                            3'd3: rx_value[15:8] = rb;
                            3'd4: rx_value[7:0] = rb;
                            default: rx_crc_low = rb;
                        endcase
                        if (rx_count < 3'd5) begin
                            rx_crc = crc16_byte(rx_crc, rb);
                        end
                        rx_count = rx_count + 3'd1;
                    end
                end
            end
            OP_TIMEOUT: begin
                if (rx_armed) begin
                    outgoing_q.push_back(pack_beat(KIND_DONE, 8'h00, 1'b0, ST_SHORT, 16'h0000));
                    rx_armed = 1'b0;
                    rx_count = '0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles = stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("modbus_rtu_single_register_read_unit verification failed");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (outgoing_q.size() == 0) begin
                    note_mismatch("unexpected beat tdata", 32'h0, m_tdata);
                end else begin
                    head_beat = outgoing_q.pop_front();
                    if (m_tuser !== head_beat.kind)
                        note_mismatch("kind", 32'(head_beat.kind), 32'(m_tuser));
                    if (m_tdata[7:0] !== head_beat.tx)
                        note_mismatch("tx_byte", 32'(head_beat.tx), 32'(m_tdata[7:0]));
                    if (m_tlast !== head_beat.last)
                        note_mismatch("last_byte", 32'(head_beat.last), 32'(m_tlast));
                    if (m_tdata[9:8] !== head_beat.status)
                        note_mismatch("status", 32'(head_beat.status), 32'(m_tdata[9:8]));
                    if (m_tdata[25:10] !== head_beat.value)
                        note_mismatch("read_value", 32'(head_beat.value),
                                      32'(m_tdata[25:10]));
                end
            end
        end
    end

    // enter and leave at a falling edge
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [7:0] sa,
                             input logic [15:0] ra, input logic [7:0] rb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {rb, ra, sa};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        modbus_master_step(op, sa, ra, rb);
        sent_items++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (outgoing_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // header flip goes in before the CRC is formed, CRC flip after it
    task automatic send_reply(input logic [7:0] sa, input logic [15:0] value,
                              input int hdr_pos, input logic [7:0] hdr_flip,
                              input int crc_pos, input logic [7:0] crc_flip,
                              input int nbytes, input int noise_pct);
        logic [7:0]  r [7];
        logic [15:0] c;
        r[0] = sa;
        r[1] = FUNC_READ_HOLDING;
        r[2] = RESP_BYTE_COUNT;
        r[3] = value[15:8];
        r[4] = value[7:0];
        r[hdr_pos] = r[hdr_pos] ^ hdr_flip;
        c = CRC_INIT;
        for (int i = 0; i < 5; i++) begin
            c = crc16_byte(c, r[i]);
        end
        r[5] = c[7:0];
        r[6] = c[15:8];
        r[crc_pos] = r[crc_pos] ^ crc_flip;
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_beat(OP_RESERVED, 8'($urandom), 16'($urandom), 8'($urandom));
            send_beat(OP_RX_BYTE, 8'($urandom), 16'($urandom), r[i]);
        end
    endtask

    task automatic run_exchange();
        logic [7:0]  sa;
        logic [15:0] ra;
        logic [15:0] value;
        logic [7:0]  hdr_flip;
        logic [7:0]  crc_flip;
        int          variant;
        int          nbytes;
        sa = pick_byte();
        ra = pick_word();
        value = pick_word();
        send_beat(OP_START, sa, ra, 8'($urandom));
        variant = $urandom_range(99);
        hdr_flip = 8'h00;
        crc_flip = 8'h00;
        nbytes = 7;
        if ((variant >= 55 && variant < 67) || (variant >= 77 && variant < 82))
            hdr_flip = 8'($urandom_range(1, 255));
        if (variant >= 67 && variant < 82)
            crc_flip = 8'($urandom_range(1, 255));
        if (variant >= 82)
            nbytes = $urandom_range(0, 6);
        send_reply(sa, value, $urandom_range(2), hdr_flip, 5 + $urandom_range(1), crc_flip,
                   nbytes, 4);
        // 92 and up: leave the reply open, the next start drops it
        if (variant >= 82 && variant < 92)
            send_beat(OP_TIMEOUT, 8'($urandom), 16'($urandom), 8'($urandom));
        if ($urandom_range(9) == 0)
            send_beat(OP_W'($urandom_range(1, 3)), 8'($urandom), 16'($urandom),
                      8'($urandom));
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int items);
        int target;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = sent_items + items;
        while (sent_items < target) run_exchange();
        wait_drained();
    endtask

    task automatic test_ignored_when_idle();
        send_beat(OP_RX_BYTE, 8'h00, 16'h0000, 8'hFF);
        send_beat(OP_TIMEOUT, 8'hFF, 16'hFFFF, 8'h00);
        send_beat(OP_RESERVED, 8'hFF, 16'hFFFF, 8'hFF);
        send_beat(OP_RX_BYTE, 8'hFF, 16'hFFFF, 8'h00);
        wait_drained();
    endtask

    task automatic test_restart_then_good_reply();
        send_beat(OP_START, 8'h00, 16'h0000, 8'h00);
        send_beat(OP_START, 8'hFF, 16'hFFFF, 8'hFF);
        send_reply(8'hFF, 16'hFFFF, 0, 8'h00, 5, 8'h00, 7, 0);
        send_beat(OP_RX_BYTE, 8'h00, 16'h0000, 8'h03);
        wait_drained();
    endtask

    task automatic test_timeout_short_reply();
        send_beat(OP_START, 8'hA5, 16'h1234, 8'h00);
        send_reply(8'hA5, 16'h0000, 0, 8'h00, 5, 8'h00, 2, 0);
        send_beat(OP_RESERVED, 8'h00, 16'h0000, 8'h00);
        send_beat(OP_TIMEOUT, 8'h00, 16'h0000, 8'h00);
        wait_drained();
    endtask

    task automatic test_header_error_wins();
        send_beat(OP_START, 8'h5A, 16'h8001, 8'h00);
        send_reply(8'h5A, 16'h0000, 1, 8'h01, 6, 8'h80, 7, 0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 55);
        run_random_phase(67, 0, 55);
        run_random_phase(0, 67, 55);
        run_random_phase(15, 15, 55);
    endtask

    // stall the output long enough to fill the unit and back up the input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (3) run_exchange();
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_ignored_when_idle();
        test_restart_then_good_reply();
        test_timeout_short_reply();
        test_header_error_wins();
        test_output_backpressure();
        test_random_traffic();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("modbus_rtu_single_register_read_unit verification clean");
        end else begin
            $display("modbus_rtu_single_register_read_unit verification failed");
        end
        $finish;
    end

endmodule
